[hw/rtl/gso_pkg.sv]
// ---------------------------------------------------------------------------
// gso_pkg
// Shared constants, codes and saturation helpers of the orthonormalizer.
// ---------------------------------------------------------------------------
package gso_pkg;

    localparam int NUM_VECS = 10;
    localparam int VEC_LEN  = 1024;

    localparam int POS_W   = 11;                         // width of vec_len
    localparam int ADDR_W  = $clog2(VEC_LEN);
    localparam int BADDR_W = $clog2(NUM_VECS * VEC_LEN);
    localparam int IDX_W   = 4;
    localparam int ELEM_W  = 16;
    localparam int WORK_W  = 32;
    localparam int ACC_W   = 48;

    typedef enum logic [1:0] {
        CMD_REF = 2'd0,
        CMD_VEC = 2'd1,
        CMD_CLR = 2'd2,
        CMD_NOP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Saturates a wide sum to the signed accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = 66'sd140737488355327;
            lo = -hi - 66'sd1;
            if (x > hi)
                sat_acc = ACC_W'(hi);
            else if (x < lo)
                sat_acc = ACC_W'(lo);
            else
                sat_acc = ACC_W'(x);
        end
    endfunction

    // Saturates a signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        begin
            if (x > 48'sd2147483647)
                sat32 = 32'sh7fffffff;
            else if (x < -48'sd2147483648)
                sat32 = 32'sh80000000;
            else
                sat32 = 32'(x);
        end
    endfunction

endpackage

[hw/rtl/gso_if.sv]
// ---------------------------------------------------------------------------
// gso_if
// Valid/ready channels of the orthonormalizer: input items, result items
// and the length register write.
// ---------------------------------------------------------------------------
interface gso_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic signed [15:0]  element;

    modport source (output valid, cmd, element, input ready);
    modport sink   (input valid, cmd, element, output ready);
endinterface

interface gso_out_if;
    logic                valid;
    logic                ready;
    logic [3:0]          basis_index;
    logic signed [31:0]  dot_with_reference;
    logic [1:0]          status;

    modport source (output valid, basis_index, dot_with_reference, status, input ready);
    modport sink   (input valid, basis_index, dot_with_reference, status, output ready);
endinterface

interface gso_cfg_if;
    logic                valid;
    logic                ready;
    logic [10:0]         data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hw/rtl/gram_schmidt_orthonormalizer.sv]
// ---------------------------------------------------------------------------
// gram_schmidt_orthonormalizer
// Modified Gram-Schmidt over vectors held in block memories, one shared
// multiply-accumulate pipe, a bit-serial square root and divider.
// ---------------------------------------------------------------------------
// Load items are accepted whenever the block is idle. The item that completes a vector
// is answered after two memory passes per stored basis vector, a norm pass, 32 square
// root steps, the output state and, for each element, a read, a load, the division
// steps and a write. A zero norm is answered after the memory passes and the norm pass,
// a full basis straight through the output state; no item is taken meanwhile.
// Reset clears counters and control; the memories are not cleared.
module gram_schmidt_orthonormalizer (
    input  logic      clk,
    input  logic      rst_n,
    gso_in_if.sink    request,
    gso_out_if.source response,
    gso_cfg_if.sink   cfg
);
    import gso_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_DOT  = 10'b0000000010,
        S_UPD  = 10'b0000000100,
        S_NRM  = 10'b0000001000,
        S_SQRT = 10'b0000010000,
        S_DRD  = 10'b0000100000,
        S_DLD  = 10'b0001000000,
        S_DIT  = 10'b0010000000,
        S_DWR  = 10'b0100000000,
        S_RES  = 10'b1000000000
    } state_t;

    state_t state_reg;

    logic [POS_W-1:0]  vec_len_reg;
    logic [POS_W-1:0]  len;
    logic [POS_W-1:0]  in_pos_reg;
    logic [POS_W-1:0]  ref_pos_reg;
    logic [IDX_W-1:0]  count_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [POS_W-1:0]  cnt_reg;

    // Memories and their registered read data.
    logic signed [ELEM_W-1:0] ref_mem   [VEC_LEN];
    logic signed [ELEM_W-1:0] basis_mem [NUM_VECS*VEC_LEN];
    logic signed [WORK_W-1:0] work_mem  [VEC_LEN];
    logic signed [ELEM_W-1:0] ref_q;
    logic signed [ELEM_W-1:0] basis_q;
    logic signed [WORK_W-1:0] work_q;

    logic                     ref_we;
    logic [ADDR_W-1:0]        ref_wa;
    logic [ADDR_W-1:0]        ref_ra;
    logic                     work_we;
    logic [ADDR_W-1:0]        work_wa;
    logic signed [WORK_W-1:0] work_wd;
    logic [ADDR_W-1:0]        work_ra;
    logic                     basis_we;
    logic [BADDR_W-1:0]       basis_wa;
    logic signed [ELEM_W-1:0] basis_wd;
    logic [BADDR_W-1:0]       basis_ra;

    // Multiply-accumulate pipe.
    logic                     in_pass;
    logic                     issue;
    logic                     pass_done;
    logic                     s1_vld_reg;
    logic                     s2_vld_reg;
    logic [ADDR_W-1:0]        a1_reg;
    logic [ADDR_W-1:0]        a2_reg;
    logic signed [WORK_W-1:0] w2_reg;
    logic signed [63:0]       prod_reg;
    logic signed [63:0]       prod_next;
    logic signed [47:0]       p_wb;
    logic signed [47:0]       p_bc;
    logic signed [63:0]       p_ww;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [31:0]       coef_reg;
    logic signed [ACC_W-1:0]  upd_diff;

    // Square root and divider.
    logic [63:0]              sq_v_reg;
    logic [63:0]              sq_res_reg;
    logic [63:0]              sq_bit_reg;
    logic [63:0]              sq_trial;
    logic [4:0]               sq_cnt_reg;
    logic [31:0]              s_reg;
    logic [53:0]              rem_reg;
    logic [53:0]              dsr_reg;
    logic [16:0]              q_reg;
    logic [4:0]               dit_cnt_reg;
    logic                     neg_reg;
    logic                     ovf_reg;
    logic signed [ELEM_W-1:0] refe_reg;
    logic [31:0]              mag;
    logic [53:0]              dividend;
    logic signed [ELEM_W-1:0] elem;
    logic signed [31:0]       dot_prod;

    logic                     res_pend_unused;
    logic [IDX_W-1:0]         r_idx_reg;
    logic signed [31:0]       r_dot_reg;
    logic [1:0]               r_st_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic signed [31:0]       out_dot_reg;
    logic [1:0]               out_st_reg;

    logic                     accept;
    logic [POS_W:0]           in_pos_inc;
    logic [POS_W:0]           ref_pos_inc;

    assign res_pend_unused = 1'b0;

    assign len = (vec_len_reg == '0) ? POS_W'(1) :
                 (vec_len_reg > POS_W'(VEC_LEN)) ? POS_W'(VEC_LEN) : vec_len_reg;

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign cfg.ready     = 1'b1;

    assign response.valid              = out_valid_reg;
    assign response.basis_index        = out_idx_reg;
    assign response.dot_with_reference = out_dot_reg;
    assign response.status             = out_st_reg;

    assign in_pos_inc  = {1'b0, in_pos_reg} + (POS_W+1)'(1);
    assign ref_pos_inc = {1'b0, ref_pos_reg} + (POS_W+1)'(1);

    assign in_pass   = (state_reg == S_DOT) || (state_reg == S_UPD) || (state_reg == S_NRM);
    assign issue     = in_pass && (cnt_reg < len);
    assign pass_done = in_pass && (cnt_reg == len) && !s1_vld_reg && !s2_vld_reg;

    // Memory port control.
    always_comb
    begin
        ref_we   = accept && (cmd_t'(request.cmd) == CMD_REF);
        ref_wa   = ref_pos_reg[ADDR_W-1:0];
        ref_ra   = cnt_reg[ADDR_W-1:0];
        work_ra  = cnt_reg[ADDR_W-1:0];
        basis_ra = BADDR_W'(j_reg) * BADDR_W'(VEC_LEN) + BADDR_W'(cnt_reg[ADDR_W-1:0]);
        basis_wa = BADDR_W'(count_reg) * BADDR_W'(VEC_LEN) + BADDR_W'(cnt_reg[ADDR_W-1:0]);
        basis_we = (state_reg == S_DWR);
        basis_wd = elem;
        if (state_reg == S_IDLE)
        begin
            work_we = accept && (cmd_t'(request.cmd) == CMD_VEC);
            work_wa = in_pos_reg[ADDR_W-1:0];
            work_wd = WORK_W'(request.element);
        end
        else
        begin
            work_we = (state_reg == S_UPD) && s2_vld_reg;
            work_wa = a2_reg;
            work_wd = sat32(upd_diff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ref_we)
            ref_mem[ref_wa] <= request.element;
        ref_q <= ref_mem[ref_ra];
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
            work_mem[work_wa] <= work_wd;
        work_q <= work_mem[work_ra];
    end

    always_ff @(posedge clk)
    begin
        if (basis_we)
            basis_mem[basis_wa] <= basis_wd;
        basis_q <= basis_mem[basis_ra];
    end

    // Products of the first pipe stage.
    assign p_wb = work_q * basis_q;
    assign p_bc = basis_q * coef_reg;
    assign p_ww = work_q * work_q;

    always_comb
    begin
        case (state_reg)
            S_DOT:   prod_next = 64'(p_wb);
            S_UPD:   prod_next = 64'(p_bc);
            default: prod_next = p_ww;
        endcase
    end

    assign acc_sum  = sat_acc(66'(acc_reg) + 66'(prod_reg));
    assign upd_diff = ACC_W'(w2_reg) - ACC_W'($signed(prod_reg[47:0]) >>> 14);

    // Square root step and divider operands.
    assign sq_trial = sq_res_reg + sq_bit_reg;
    assign mag      = (work_q < 0) ? 32'(-64'(work_q)) : 32'(work_q);
    assign dividend = {mag, 22'b0};

    always_comb
    begin
        if (neg_reg)
            elem = (ovf_reg || q_reg > 17'd32768) ? -16'sd32768 : -$signed(q_reg[15:0]);
        else
            elem = (ovf_reg || q_reg > 17'd32767) ? 16'sd32767 : $signed(q_reg[15:0]);
    end

    assign dot_prod = elem * refe_reg;

    always_ff @(posedge clk)
    begin
        s1_vld_reg <= issue;
        s2_vld_reg <= s1_vld_reg;
        a1_reg     <= cnt_reg[ADDR_W-1:0];
        a2_reg     <= a1_reg;
        w2_reg     <= work_q;
        prod_reg   <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vec_len_reg   <= POS_W'(VEC_LEN);
            in_pos_reg    <= '0;
            ref_pos_reg   <= '0;
            count_reg     <= '0;
            j_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                vec_len_reg <= cfg.data;
            if (response.ready && state_reg != S_RES)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd_t'(request.cmd))
                            CMD_REF:
                                ref_pos_reg <= (ref_pos_inc >= {1'b0, len}) ? '0
                                                                         : ref_pos_inc[POS_W-1:0];
                            CMD_VEC:
                            begin
                                if (in_pos_inc >= {1'b0, len})
                                begin
                                    in_pos_reg <= '0;
                                    cnt_reg    <= '0;
                                    j_reg      <= '0;
                                    acc_reg    <= '0;
                                    if (count_reg >= IDX_W'(NUM_VECS))
                                    begin
                                        r_idx_reg <= '0;
                                        r_dot_reg <= '0;
                                        r_st_reg  <= ST_FULL;
                                        state_reg <= S_RES;
                                    end
                                    else if (count_reg == '0)
                                        state_reg <= S_NRM;
                                    else
                                        state_reg <= S_DOT;
                                end
                                else
                                    in_pos_reg <= in_pos_inc[POS_W-1:0];
                            end
                            CMD_CLR:
                                count_reg <= '0;
                            default:
                                ;
                        endcase
                    end
                end
                S_DOT, S_UPD, S_NRM:
                begin
                    if (issue)
                        cnt_reg <= cnt_reg + POS_W'(1);
                    if (s2_vld_reg && state_reg != S_UPD)
                        acc_reg <= acc_sum;
                    if (pass_done)
                    begin
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        if (state_reg == S_DOT)
                        begin
                            coef_reg  <= sat32(acc_reg >>> 14);
                            state_reg <= S_UPD;
                        end
                        else if (state_reg == S_UPD)
                        begin
                            j_reg     <= j_reg + IDX_W'(1);
                            state_reg <= (j_reg + IDX_W'(1) == count_reg) ? S_NRM : S_DOT;
                        end
                        else if (acc_reg <= 0)
                        begin
                            r_idx_reg <= count_reg;
                            r_dot_reg <= '0;
                            r_st_reg  <= ST_ZERO;
                            state_reg <= S_RES;
                        end
                        else
                        begin
                            sq_v_reg   <= 64'(acc_reg) << 16;
                            sq_res_reg <= '0;
                            sq_bit_reg <= 64'd1 << 62;
                            sq_cnt_reg <= '0;
                            state_reg  <= S_SQRT;
                        end
                    end
                end
                S_SQRT:
                begin
                    if (sq_v_reg >= sq_trial)
                    begin
                        sq_v_reg   <= sq_v_reg - sq_trial;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_res_reg <= sq_res_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg + 5'd1;
                    if (sq_cnt_reg == 5'd31)
                    begin
                        // The last step always leaves the result in the shifted form.
                        s_reg     <= (sq_v_reg >= sq_trial) ? 32'((sq_res_reg >> 1) + sq_bit_reg)
                                                            : 32'(sq_res_reg >> 1);
                        state_reg <= S_DRD;
                    end
                end
                S_DRD:
                    state_reg <= S_DLD;
                S_DLD:
                begin
                    neg_reg     <= (work_q < 0);
                    refe_reg    <= ref_q;
                    ovf_reg     <= (dividend >= {5'b0, s_reg, 17'b0});
                    rem_reg     <= dividend;
                    dsr_reg     <= {6'b0, s_reg, 16'b0};
                    q_reg       <= '0;
                    dit_cnt_reg <= '0;
                    state_reg   <= S_DIT;
                end
                S_DIT:
                begin
                    if (rem_reg >= dsr_reg)
                    begin
                        rem_reg <= rem_reg - dsr_reg;
                        q_reg   <= {q_reg[15:0], 1'b1};
                    end
                    else
                        q_reg <= {q_reg[15:0], 1'b0};
                    dsr_reg     <= dsr_reg >> 1;
                    dit_cnt_reg <= dit_cnt_reg + 5'd1;
                    if (dit_cnt_reg == 5'd16)
                        state_reg <= S_DWR;
                end
                S_DWR:
                begin
                    acc_reg <= sat_acc(66'(acc_reg) + 66'(dot_prod));
                    if (cnt_reg + POS_W'(1) == len)
                    begin
                        r_idx_reg <= count_reg;
                        r_dot_reg <= sat32(sat_acc(66'(acc_reg) + 66'(dot_prod)) >>> 4);
                        r_st_reg  <= ST_OK;
                        count_reg <= count_reg + IDX_W'(1);
                        state_reg <= S_RES;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + POS_W'(1);
                        state_reg <= S_DRD;
                    end
                end
                S_RES:
                begin
                    if (!out_valid_reg || response.ready || res_pend_unused)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= r_idx_reg;
                        out_dot_reg   <= r_dot_reg;
                        out_st_reg    <= r_st_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[verif/gram_schmidt_orthonormalizer_tb.sv]
// ---------------------------------------------------------------------------
// gram_schmidt_orthonormalizer_tb
// Self-checking testbench: a directed table followed by randomized phases of
// vector lengths, checked item by item against a fixed-point predictor.
// ---------------------------------------------------------------------------
module gram_schmidt_orthonormalizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gso_pkg::*;

    localparam longint ACC_HI     = 64'sd140737488355327;
    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     DRAIN_GAP   = 80;
    localparam int     RANDOM_ITEMS = 1100;

    typedef struct {
        logic [3:0]         idx;
        logic signed [31:0] dot;
        status_t            st;
    } result_t;

    typedef struct {
        bit                 is_cfg;
        cmd_t               cmd;
        logic signed [15:0] elem;
        bit                 typed;
        result_t            want;
    } row_t;

    logic clk;
    logic rst_n;

    gso_in_if  req();
    gso_out_if resp();
    gso_cfg_if cfg();

    gram_schmidt_orthonormalizer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req),
        .response (resp),
        .cfg      (cfg)
    );

    // Predictor state.
    shortint     ref_mem [VEC_LEN];
    shortint     basis_mem [NUM_VECS][VEC_LEN];
    int          work_mem [VEC_LEN];
    int unsigned nbasis;
    int unsigned in_pos;
    int unsigned ref_pos;
    int unsigned len_reg;

    result_t pending_results[$];
    result_t got;
    row_t    directed[$];

    int  errors;
    int  items_sent;
    int  random_items;
    int  vectors_done;
    int  seen_ok, seen_zero, seen_full;
    int  cycles;
    bit  calm;
    bit  hold_req;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint acc_sum(longint a, longint p);
        longint s;
        s = a + p;
        if (s > ACC_HI)
            return ACC_HI;
        if (s < -ACC_HI - 1)
            return -ACC_HI - 1;
        return s;
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Orthogonalizes the working vector against the basis, normalizes it and
    // stores it, returning the result item; a full basis or a zero norm stores nothing.
    function automatic result_t close_vector(int n);
        result_t         r;
        longint          acc;
        longint          coef;
        longint          d;
        longint          w;
        longint unsigned s;
        longint unsigned mag;
        longint unsigned q;
        r.idx = 4'd0;
        r.dot = 32'sd0;
        r.st  = ST_FULL;
        if (nbasis >= NUM_VECS)
            return r;
        for (int j = 0; j < nbasis; j++)
        begin
            acc = 0;
            for (int l = 0; l < n; l++)
                acc = acc_sum(acc, longint'(work_mem[l]) * longint'(basis_mem[j][l]));
            coef = clip32(acc >>> 14);
            for (int l = 0; l < n; l++)
            begin
                d = (longint'(basis_mem[j][l]) * coef) >>> 14;
                work_mem[l] = int'(clip32(longint'(work_mem[l]) - d));
            end
        end
        acc = 0;
        for (int l = 0; l < n; l++)
            acc = acc_sum(acc, longint'(work_mem[l]) * longint'(work_mem[l]));
        r.idx = 4'(nbasis);
        if (acc <= 0)
        begin
            r.st = ST_ZERO;
            return r;
        end
        s = root64(longint'(acc) << 16);
        for (int l = 0; l < n; l++)
        begin
            w = work_mem[l];
            mag = (w < 0) ? -w : w;
            q = (mag << 22) / s;
            if (w < 0)
                basis_mem[nbasis][l] = (q > 32768) ? -16'sd32768 : shortint'(-longint'(q));
            else
                basis_mem[nbasis][l] = (q > 32767) ? 16'sd32767 : shortint'(q);
        end
        acc = 0;
        for (int l = 0; l < n; l++)
            acc = acc_sum(acc, longint'(basis_mem[nbasis][l]) * longint'(ref_mem[l]));
        r.dot = 32'(clip32(acc >>> 4));
        r.st  = ST_OK;
        nbasis++;
        return r;
    endfunction

    function automatic bit predict_item(cmd_t c, logic signed [15:0] e, output result_t r);
        int unsigned n;
        n = (len_reg == 0) ? 1 : ((len_reg > VEC_LEN) ? VEC_LEN : len_reg);
        case (c)
            CMD_REF:
            begin
                if (ref_pos < VEC_LEN)
                    ref_mem[ref_pos] = e;
                ref_pos++;
                if (ref_pos >= n)
                    ref_pos = 0;
            end
            CMD_VEC:
            begin
                if (in_pos < VEC_LEN)
                    work_mem[in_pos] = e;
                in_pos++;
                if (in_pos >= n)
                begin
                    in_pos = 0;
                    r = close_vector(n);
                    return 1'b1;
                end
            end
            CMD_CLR:
                nbasis = 0;
            default:
                ;
        endcase
        return 1'b0;
    endfunction

    function automatic logic signed [15:0] rnd_elem();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1:       return 16'sd0;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(0, 4096)) - 16'sd2048;
        endcase
    endfunction

    // Offers one item and holds it until accepted; the predictor runs on
    // acceptance. A typed expectation, when given, replaces the predicted one.
    task automatic put(cmd_t c, logic signed [15:0] e, bit typed = 0, result_t want = '{0, 0, ST_OK});
        result_t r;
        req.valid   <= 1'b1;
        req.cmd     <= c;
        req.element <= e;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        items_sent++;
        if (predict_item(c, e, r))
            pending_results.push_back(typed ? want : r);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_len(logic [10:0] v);
        req.valid <= 1'b0;
        drain();
        repeat (DRAIN_GAP) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        len_reg = v;
    endtask

    function automatic void add_row(bit is_cfg, cmd_t c, int e, bit typed = 0,
                                    result_t want = '{0, 0, ST_OK});
        row_t r;
        r.is_cfg = is_cfg;
        r.cmd    = c;
        r.elem   = 16'(e);
        r.typed  = typed;
        r.want   = want;
        directed.push_back(r);
    endfunction

    // One phase at a given length: clear, full reference load, then vectors
    // with some noise in between.
    task automatic run_phase(logic [10:0] lv, int nvec);
        int  n;
        bit  zero_vec;
        n = (lv == 0) ? 1 : ((lv > VEC_LEN) ? VEC_LEN : lv);
        write_len(lv);
        put(CMD_CLR, rnd_elem());
        // One extra element covers a reference position left above the length.
        for (int k = 0; k <= n; k++)
            put(CMD_REF, rnd_elem());
        for (int v = 0; v < nvec; v++)
        begin
            if ($urandom_range(0, 9) == 0)
                put(CMD_NOP, rnd_elem());
            if ($urandom_range(0, 14) == 0)
                put(CMD_CLR, rnd_elem());
            zero_vec = ($urandom_range(0, 11) == 0);
            for (int l = 0; l < n; l++)
            begin
                if (l == n / 2 && $urandom_range(0, 14) == 0)
                    put(CMD_REF, rnd_elem());
                put(CMD_VEC, zero_vec ? 16'sd0 : rnd_elem());
            end
            if (!hold_req && random_items + items_sent > 0 && items_sent > 600
                && items_sent < 700)
                hold_req = 1'b1;
        end
    endtask

    // Receiver side: random stalls plus long hold-offs on request.
    initial
    begin
        resp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                resp.ready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                resp.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
                resp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (resp.valid && resp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result item idx=%0d dot=%0d status=%0d", $time,
                         resp.basis_index, resp.dot_with_reference, resp.status);
            end
            else
            begin
                got = pending_results.pop_front();
                vectors_done++;
                case (got.st)
                    ST_OK:   seen_ok++;
                    ST_ZERO: seen_zero++;
                    default: seen_full++;
                endcase
                if (resp.basis_index !== got.idx)
                begin
                    errors++;
                    $display("%0t: basis_index expected %0d actual %0d", $time,
                             got.idx, resp.basis_index);
                end
                if (resp.dot_with_reference !== got.dot)
                begin
                    errors++;
                    $display("%0t: dot_with_reference expected %0d actual %0d", $time,
                             got.dot, resp.dot_with_reference);
                end
                if (resp.status !== got.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             got.st, resp.status);
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("gram_schmidt_orthonormalizer_tb NOT OK");
        $finish;
    end

    initial
    begin
        errors       = 0;
        items_sent   = 0;
        random_items = 0;
        vectors_done = 0;
        seen_ok      = 0;
        seen_zero    = 0;
        seen_full    = 0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        nbasis       = 0;
        in_pos       = 0;
        ref_pos      = 0;
        len_reg      = 1024;
        rst_n        <= 1'b0;
        req.valid    <= 1'b0;
        req.cmd      <= CMD_NOP;
        req.element  <= 16'sd0;
        cfg.valid    <= 1'b0;
        cfg.data     <= 11'd0;

        // Length 2: zero vector, unit vector, extremes, clear and no-op.
        add_row(1, CMD_NOP, 2);
        add_row(0, CMD_REF, 16384);
        add_row(0, CMD_REF, 0);
        add_row(0, CMD_VEC, 0);
        add_row(0, CMD_VEC, 0, 1, '{4'd0, 32'sd0, ST_ZERO});
        add_row(0, CMD_VEC, 16384);
        add_row(0, CMD_VEC, 0, 1, '{4'd0, 32'sd16777216, ST_OK});
        add_row(0, CMD_VEC, 32767);
        add_row(0, CMD_VEC, -32768);
        add_row(0, CMD_VEC, -32768);
        add_row(0, CMD_VEC, 32767);
        add_row(0, CMD_CLR, 0);
        add_row(0, CMD_NOP, -1);
        add_row(0, CMD_REF, -32768);
        add_row(0, CMD_REF, 32767);
        add_row(0, CMD_VEC, -32768);
        add_row(0, CMD_VEC, -32768);
        // Length 4, then lowered to 2 while a vector is half loaded.
        add_row(1, CMD_NOP, 4);
        add_row(0, CMD_CLR, 0);
        add_row(0, CMD_REF, 100);
        add_row(0, CMD_REF, -200);
        add_row(0, CMD_REF, 32767);
        add_row(0, CMD_REF, -32768);
        add_row(0, CMD_REF, 5);
        add_row(0, CMD_VEC, 1);
        add_row(0, CMD_VEC, 2);
        add_row(0, CMD_VEC, 3);
        add_row(0, CMD_VEC, 4);
        add_row(0, CMD_VEC, 7);
        add_row(0, CMD_VEC, -9);
        add_row(1, CMD_NOP, 2);
        add_row(0, CMD_VEC, 11);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                write_len(11'(directed[i].elem));
            else
                put(directed[i].cmd, directed[i].elem, directed[i].typed, directed[i].want);
        end

        random_items = items_sent;
        while (items_sent - random_items < RANDOM_ITEMS)
        begin
            if (items_sent - random_items > RANDOM_ITEMS * 5 / 6)
                calm = 1'b1;
            case ($urandom_range(0, 9))
                0:       run_phase(11'd0, $urandom_range(2, 6));
                1:       run_phase(11'd1, $urandom_range(2, 6));
                2:       run_phase(11'd12, $urandom_range(10, 14));
                default: run_phase(11'($urandom_range(2, 16)), $urandom_range(3, 14));
            endcase
        end

        req.valid <= 1'b0;
        drain();
        repeat (DRAIN_GAP) @(posedge clk);
        $display("Sent %0d items over lengths 1 to 16; %0d results checked.",
                 items_sent, vectors_done);
        $display("Results: %0d stored, %0d zero norm, %0d with the basis full.",
                 seen_ok, seen_zero, seen_full);
        if (errors == 0)
            $display("gram_schmidt_orthonormalizer_tb OK");
        else
            $display("gram_schmidt_orthonormalizer_tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/gso_pkg.sv
hw/rtl/gso_if.sv
hw/rtl/gram_schmidt_orthonormalizer.sv
verif/gram_schmidt_orthonormalizer_tb.sv
